// File: design/npfh_pkg.sv
// ----------------------------------------------------------------------------
// npfh_pkg - shared types, constants and functions of the path hash unit
// FNV-1a constants, the byte classes for Shift-JIS lead bytes, byte
// normalization, and the multiply by the FNV prime as shifted adds.
// ----------------------------------------------------------------------------
`default_nettype none

package npfh_pkg;

  localparam int HASH_W = 32;
  localparam int BYTE_W = 8;
  localparam int MB_W   = 2;

  typedef logic [HASH_W-1:0] hash_t;
  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [MB_W-1:0]   mb_cnt_t;

  localparam hash_t FNV_OFFSET = 32'h811C_9DC5;
  localparam hash_t FNV_PRIME  = 32'h0100_0193;

  // Shift-JIS lead byte ranges
  localparam byte_t LEAD_LO_A = 8'h81;
  localparam byte_t LEAD_HI_A = 8'h9F;
  localparam byte_t LEAD_LO_B = 8'hE0;

  localparam byte_t UPPER_A   = 8'h41;
  localparam byte_t UPPER_Z   = 8'h5A;
  localparam byte_t CASE_OFS  = 8'h20;
  localparam byte_t SLASH     = 8'h2F;
  localparam byte_t BACKSLASH = 8'h5C;

  // Raw run length that a lead byte starts: the lead byte and its trail byte
  localparam mb_cnt_t MB_PAIR = 2'd2;
  localparam mb_cnt_t MB_NONE = 2'd0;

  function automatic logic is_lead_byte(input byte_t b);
    is_lead_byte = ((b >= LEAD_LO_A) && (b <= LEAD_HI_A)) || (b >= LEAD_LO_B);
  endfunction

  function automatic byte_t normalize_byte(input byte_t b);
    byte_t r;
    r = b;
    if ((b >= UPPER_A) && (b <= UPPER_Z)) begin
      r = b + CASE_OFS;
    end else if (b == SLASH) begin
      r = BACKSLASH;
    end
    normalize_byte = r;
  endfunction

  // x * 0x01000193 mod 2^32: bits 24, 8, 7, 4, 1 and 0 of the prime
  function automatic hash_t mul_fnv_prime(input hash_t x);
    mul_fnv_prime = (x << 24) + (x << 8) + (x << 7) + (x << 4) + (x << 1) + x;
  endfunction

endpackage

`default_nettype wire

// File: design/npfh_if.sv
// ----------------------------------------------------------------------------
// npfh_in_if / npfh_out_if - valid/ready channels of the path hash unit
// The input channel carries one path byte per beat, the output channel one
// finished hash per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface npfh_in_if;
  logic              valid;
  logic              ready;
  npfh_pkg::byte_t   char_byte;
  logic              is_last;

  modport source (output valid, output char_byte, output is_last, input ready);
  modport sink   (input valid, input char_byte, input is_last, output ready);
endinterface

interface npfh_out_if;
  logic              valid;
  logic              ready;
  npfh_pkg::hash_t   hash_value;

  modport source (output valid, output hash_value, input ready);
  modport sink   (input valid, input hash_value, output ready);
endinterface

`default_nettype wire

// File: design/normalized_path_fnv1a_hash_unit.sv
// ----------------------------------------------------------------------------
// normalized_path_fnv1a_hash_unit - normalized path hash, FNV-1a 32 bit
// Folds a path string, one byte per beat, into an FNV-1a state and returns
// the negated hash when the byte flagged last has been folded in.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one path byte per beat, is_last flags the final byte of a string.
//   out_ch : one beat per string, hash_value = 0 - final FNV-1a state.
//   cfg_*  : cfg_wr_en writes cfg_wr_data into the seed register; the running
//            state reloads from it and any string in progress restarts.
//            Write only while the unit is idle.
// Path: a byte is captured in the input register at its beat and folded into
//   the state from there; the hash of a last byte lands in the result register
//   and is valid on out_ch from it, when the result register is free.
// Throughput: one byte per cycle, save while a last byte waits for the result
//   register. The fold (XOR, multiply by the prime as six shifted adds, negate)
//   sits between the input register and the state and result registers.
// Reset: seed returns to 0x811C9DC5, state to the seed, the multibyte count to
//   zero, both registers empty.
// Stall: while a hash waits on out_ch, non-final bytes keep flowing; a last
//   byte holds in the input register until the result register frees, and
//   in_ch.ready stays low only while it holds.
// ----------------------------------------------------------------------------
`default_nettype none

module normalized_path_fnv1a_hash_unit (
  input  wire logic            clk,
  input  wire logic            rst_n,
  npfh_in_if.sink              in_ch,
  npfh_out_if.source           out_ch,
  input  wire logic            cfg_wr_en,
  input  wire npfh_pkg::hash_t cfg_wr_data
);
  import npfh_pkg::*;

  // seed and running state
  hash_t   init_hash_r;
  hash_t   running_hash_r, running_hash_nxt;
  mb_cnt_t mb_left_r, mb_left_nxt;

  // input register
  logic    s1_valid_r;
  byte_t   s1_byte_r;
  logic    s1_last_r;

  // result register
  logic    out_valid_r;
  hash_t   out_hash_r;

  logic    s1_fire;
  logic    in_fire;
  logic    out_free;
  logic    raw_byte;
  byte_t   fold_byte;
  hash_t   fold_ext;
  hash_t   fold_hash;

  assign out_free = !out_valid_r || out_ch.ready;
  // a non-final byte never needs the result register
  assign s1_fire  = s1_valid_r && (!s1_last_r || out_free);
  assign in_ch.ready = !s1_valid_r || s1_fire;
  assign in_fire  = in_ch.valid && in_ch.ready;

  // Byte class: a lead byte (or the byte after one) passes raw
  always_comb begin
    mb_left_nxt = mb_left_r;
    raw_byte    = 1'b0;
    if (mb_left_r == MB_NONE && is_lead_byte(s1_byte_r)) begin
      raw_byte    = 1'b1;
      mb_left_nxt = MB_PAIR - 2'd1;
    end else if (mb_left_r != MB_NONE) begin
      raw_byte    = 1'b1;
      mb_left_nxt = mb_left_r - 2'd1;
    end
    fold_byte = raw_byte ? s1_byte_r : normalize_byte(s1_byte_r);
    // sign-extend, XOR, multiply by the prime
    fold_ext  = {{(HASH_W-BYTE_W){fold_byte[BYTE_W-1]}}, fold_byte};
    fold_hash = mul_fnv_prime(running_hash_r ^ fold_ext);
    running_hash_nxt = fold_hash;
    if (s1_last_r) begin
      // end of string: reload the seed, drop a cut-short pair
      running_hash_nxt = init_hash_r;
      mb_left_nxt      = MB_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_hash_r    <= FNV_OFFSET;
      running_hash_r <= FNV_OFFSET;
      mb_left_r      <= MB_NONE;
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        init_hash_r    <= cfg_wr_data;
        running_hash_r <= cfg_wr_data;
        mb_left_r      <= MB_NONE;
      end else if (s1_fire) begin
        running_hash_r <= running_hash_nxt;
        mb_left_r      <= mb_left_nxt;
      end

      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end

      if (s1_fire && s1_last_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_ch.char_byte;
      s1_last_r <= in_ch.is_last;
    end
    if (s1_fire && s1_last_r) begin
      out_hash_r <= hash_t'(0) - fold_hash;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.hash_value = out_hash_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------

  // the raw countdown never sits above one between bytes
  a_mb_range: assert property (@(posedge clk) disable iff (!rst_n)
    mb_left_r[1] == 1'b0)
    else $error("multibyte countdown out of range");

  // a finished string leaves the state at the seed and the countdown clear
  a_string_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_last_r && !cfg_wr_en) |=>
      (running_hash_r == init_hash_r) && (mb_left_r == MB_NONE))
    else $error("state not reloaded after last byte");

  // input stalls only behind a last byte that waits for the result register
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (s1_valid_r && s1_last_r && out_valid_r && !out_ch.ready))
    else $error("input stalled without a blocked last byte");

  // a last byte that moves on always lands a result
  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_last_r) |=> out_valid_r)
    else $error("last byte produced no result");

endmodule

`default_nettype wire
